FILE: rtl/cp_pkg.sv
// Shared constants, types and the arctangent step table for cartesian_to_polar.
package cp_pkg;

  localparam int DATA_W   = 16;              // input and output field width
  localparam int WORD_W   = 2 * DATA_W;      // tdata width on both sides
  localparam int ITERS    = 20;              // CORDIC iterations
  localparam int PRESHIFT = 14;              // CORDIC input left shift
  localparam int XY_W     = 32;              // CORDIC x/y datapath
  localparam int Z_W      = 24;              // angle accumulator, 2^-24 turn units
  localparam int ROOT_W   = 16;              // square root result bits
  localparam int REM_W    = ROOT_W + 1;      // partial remainder, <= 2*root
  localparam int SQ_W     = 2 * DATA_W;      // re^2 + im^2

  // squares, sum, one stage per root bit, round
  localparam int MAG_CORE_LAT = 2 + ROOT_W + 1;
  // prerotation, one stage per iteration, round
  localparam int PIPE_LAT     = 1 + ITERS + 1;
  localparam int MAG_PAD      = PIPE_LAT - MAG_CORE_LAT;

  localparam int OUT_DEPTH = 32;             // output buffer words

  localparam logic [Z_W-1:0] Z_HALF = Z_W'(1) << (Z_W - 1);
  localparam logic [Z_W-1:0] Z_RND  = Z_W'(1) << (Z_W - DATA_W - 1);

  typedef logic [WORD_W-1:0] word_t;

  // Quarter-turn code; phase on an axis is code * 2^14.
  typedef enum logic [1:0] {
    AX_POS_RE = 2'b00,
    AX_POS_IM = 2'b01,
    AX_NEG_RE = 2'b10,
    AX_NEG_IM = 2'b11
  } axis_t;

  typedef struct packed {
    logic  on_axis;
    axis_t axis;
  } axis_tag_t;

  // round(atan(2^-i) / (2*pi) * 2^24)
  function automatic logic [Z_W-1:0] atan_step(input int i);
    logic [Z_W-1:0] a;
    case (i)
      0:  a = Z_W'(2097152);
      1:  a = Z_W'(1238021);
      2:  a = Z_W'(654136);
      3:  a = Z_W'(332050);
      4:  a = Z_W'(166669);
      5:  a = Z_W'(83416);
      6:  a = Z_W'(41718);
      7:  a = Z_W'(20860);
      8:  a = Z_W'(10430);
      9:  a = Z_W'(5215);
      10: a = Z_W'(2608);
      11: a = Z_W'(1304);
      12: a = Z_W'(652);
      13: a = Z_W'(326);
      14: a = Z_W'(163);
      15: a = Z_W'(81);
      16: a = Z_W'(41);
      17: a = Z_W'(20);
      18: a = Z_W'(10);
      19: a = Z_W'(5);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/cp_mag_pipe.sv
// Magnitude pipeline: squares, sum, bit-per-stage square root, rounding.
module cp_mag_pipe (
  input  logic                             clk,
  input  logic signed [cp_pkg::DATA_W-1:0] re_part,
  input  logic signed [cp_pkg::DATA_W-1:0] im_part,
  output logic        [cp_pkg::DATA_W-1:0] mag
);
  import cp_pkg::*;

  logic signed [SQ_W-1:0] p_re;
  logic signed [SQ_W-1:0] p_im;
  logic [SQ_W-1:0]   sq_re;
  logic [SQ_W-1:0]   sq_im;
  logic [SQ_W-1:0]   s_st [0:ROOT_W];
  logic [REM_W-1:0]  rem  [0:ROOT_W];
  logic [ROOT_W-1:0] root [0:ROOT_W];
  logic [ROOT_W-1:0] mag_core;
  logic [ROOT_W-1:0] pad  [0:MAG_PAD];

  assign p_re = re_part * re_part;
  assign p_im = im_part * im_part;

  always_ff @(posedge clk) begin
    sq_re   <= unsigned'(p_re);
    sq_im   <= unsigned'(p_im);
    s_st[0] <= sq_re + sq_im;   // at most 2^31, no carry out
    rem[0]  <= '0;
    root[0] <= '0;
  end

  // one root bit per stage, most significant first
  for (genvar j = 0; j < ROOT_W; j++) begin : g_step
    localparam int K = ROOT_W - 1 - j;
    logic [REM_W+1:0] rem_new;
    logic [REM_W+1:0] trial;
    logic             ge;

    assign rem_new = {rem[j], s_st[j][2*K+1 -: 2]};
    assign trial   = {1'b0, root[j], 2'b01};
    assign ge      = rem_new >= trial;

    always_ff @(posedge clk) begin
      s_st[j+1] <= s_st[j];
      rem[j+1]  <= ge ? REM_W'(rem_new - trial) : REM_W'(rem_new);
      root[j+1] <= {root[j][ROOT_W-2:0], ge};
    end
  end

  // remainder is s - r^2, so s > r^2 + r exactly when rem > r
  always_ff @(posedge clk) begin
    mag_core <= root[ROOT_W] + ROOT_W'(rem[ROOT_W] > {1'b0, root[ROOT_W]});
  end

  // align with the phase pipeline
  assign pad[0] = mag_core;
  for (genvar p = 0; p < MAG_PAD; p++) begin : g_pad
    always_ff @(posedge clk) begin
      pad[p+1] <= pad[p];
    end
  end

  assign mag = pad[MAG_PAD];

endmodule

FILE: rtl/cp_phase_pipe.sv
// Phase pipeline: half-plane prerotation, vectoring CORDIC stages, rounding.
module cp_phase_pipe (
  input  logic                             clk,
  input  logic signed [cp_pkg::DATA_W-1:0] re_part,
  input  logic signed [cp_pkg::DATA_W-1:0] im_part,
  output logic        [cp_pkg::DATA_W-1:0] turn_phase
);
  import cp_pkg::*;

  logic signed [XY_W-1:0] re_ext;
  logic signed [XY_W-1:0] im_ext;
  logic signed [XY_W-1:0] x   [0:ITERS];
  logic signed [XY_W-1:0] y   [0:ITERS];
  logic        [Z_W-1:0]  z   [0:ITERS];
  axis_tag_t              tag [0:ITERS];
  axis_tag_t              tag_in;
  logic        [Z_W-1:0]  z_rnd;

  assign re_ext = XY_W'(re_part);
  assign im_ext = XY_W'(im_part);

  always_comb begin
    tag_in.on_axis = (re_part == '0) || (im_part == '0);
    if (im_part == '0) begin
      tag_in.axis = re_part[DATA_W-1] ? AX_NEG_RE : AX_POS_RE;
    end else begin
      tag_in.axis = im_part[DATA_W-1] ? AX_NEG_IM : AX_POS_IM;
    end
  end

  // left half plane: negate and start at a half turn
  always_ff @(posedge clk) begin
    tag[0] <= tag_in;
    if (re_part[DATA_W-1]) begin
      x[0] <= (-re_ext) <<< PRESHIFT;
      y[0] <= (-im_ext) <<< PRESHIFT;
      z[0] <= Z_HALF;
    end else begin
      x[0] <= re_ext <<< PRESHIFT;
      y[0] <= im_ext <<< PRESHIFT;
      z[0] <= '0;
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    localparam logic [Z_W-1:0] A = atan_step(i);
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;

    always_ff @(posedge clk) begin
      tag[i+1] <= tag[i];
      if (!y[i][XY_W-1]) begin
        x[i+1] <= x[i] + dx;
        y[i+1] <= y[i] - dy;
        z[i+1] <= z[i] + A;
      end else begin
        x[i+1] <= x[i] - dx;
        y[i+1] <= y[i] + dy;
        z[i+1] <= z[i] - A;
      end
    end
  end

  // full-turn results wrap to zero through the modulo 2^24 add
  assign z_rnd = z[ITERS] + Z_RND;

  always_ff @(posedge clk) begin
    if (tag[ITERS].on_axis) begin
      turn_phase <= {tag[ITERS].axis, {(DATA_W-2){1'b0}}};
    end else begin
      turn_phase <= z_rnd[Z_W-1 -: DATA_W];
    end
  end

endmodule

FILE: rtl/cp_out_fifo.sv
// Output word buffer between the free-running pipeline and the result port.
module cp_out_fifo #(
  parameter int DEPTH = cp_pkg::OUT_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cp_pkg::word_t push_data,
  input  logic          pop,
  output logic          valid,
  output cp_pkg::word_t data
);
  import cp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  word_t         mem [0:DEPTH-1];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;        // words in mem, output register not included
  logic [CW-1:0] count_next;
  logic          load;         // output register takes the next word
  logic          from_mem;
  logic          wr_en;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign load     = !valid || pop;
  assign from_mem = load && (count != '0);
  // an empty mem with a free output register passes the word straight through
  assign wr_en    = push && !(load && (count == '0));

  always_comb begin
    count_next = count;
    case ({wr_en, from_mem})
      2'b10:   count_next = count + CW'(1);
      2'b01:   count_next = count - CW'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= push_data;
    end
    if (from_mem) begin
      data <= mem[rd_ptr];
    end else if (load && push) begin
      data <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (from_mem) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count_next;
      if (load) begin
        valid <= from_mem || push;
      end
    end
  end

endmodule

FILE: rtl/cartesian_to_polar.sv
// Top level of cartesian_to_polar: complex sample in, magnitude and turn phase out.
//
//   channel   dir  handshake                  payload
//   s_axis    in   s_axis_tvalid/tready       re_part, im_part (Q1.15)
//   m_axis    out  m_axis_tvalid/tready       mag, turn_phase
//
// One word per cycle in and out while m_axis_tready stays high. The path
// from input accept to the word entering the output buffer is set by the
// 20 CORDIC stages plus prerotation and rounding; the magnitude side (squares,
// sum, 16 root stages, rounding) is padded to match.
// The pipeline never stalls. A credit count of words in flight plus words
// buffered gates s_axis_tready, so a stalled output fills the buffer and
// then holds off the input; nothing is dropped.
// Reset (rst, synchronous) clears the valid line, credits and buffer
// pointers; datapath registers are not reset.
module cartesian_to_polar #(
  parameter int OUT_DEPTH = cp_pkg::OUT_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  cp_pkg::word_t s_axis_tdata,   // [15:0] re_part, [31:16] im_part
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output cp_pkg::word_t m_axis_tdata    // [15:0] mag, [31:16] turn_phase
);
  import cp_pkg::*;

  localparam int CW = $clog2(OUT_DEPTH + 1);

  logic                     in_acc;
  logic                     out_acc;
  logic signed [DATA_W-1:0] re_part;
  logic signed [DATA_W-1:0] im_part;
  logic        [DATA_W-1:0] mag;
  logic        [DATA_W-1:0] turn_phase;
  logic [PIPE_LAT-1:0]      vld;
  logic [CW-1:0]            credit;
  logic [CW-1:0]            credit_next;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  assign re_part = signed'(s_axis_tdata[DATA_W-1:0]);
  assign im_part = signed'(s_axis_tdata[WORD_W-1:DATA_W]);

  // both datapaths run every cycle; vld marks which stages hold real words
  cp_mag_pipe u_mag (
    .clk     (clk),
    .re_part (re_part),
    .im_part (im_part),
    .mag     (mag)
  );

  cp_phase_pipe u_phase (
    .clk        (clk),
    .re_part    (re_part),
    .im_part    (im_part),
    .turn_phase (turn_phase)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_LAT-2:0], in_acc};
    end
  end

  // credits = words in the pipeline + words in the buffer
  always_comb begin
    credit_next = credit;
    case ({in_acc, out_acc})
      2'b10:   credit_next = credit + CW'(1);
      2'b01:   credit_next = credit - CW'(1);
      default: credit_next = credit;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit_next;
    end
  end

  // no word is taken while reset is held
  assign s_axis_tready = !rst && (credit < CW'(OUT_DEPTH));

  cp_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (vld[PIPE_LAT-1]),
    .push_data ({turn_phase, mag}),
    .pop       (out_acc),
    .valid     (m_axis_tvalid),
    .data      (m_axis_tdata)
  );

  // credit bounds the buffer fill, so it can never overflow
  a_credit_max: assert property (@(posedge clk) disable iff (rst)
    credit <= CW'(OUT_DEPTH))
    else $error("credit count above buffer depth");

  // every accepted word reaches the buffer as a push from the last vld stage
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> ##PIPE_LAT vld[PIPE_LAT-1])
    else $error("accepted word lost in pipeline");

  // a buffered or emerging word must be covered by a credit
  a_out_credit: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid || vld[PIPE_LAT-1]) |-> credit != '0)
    else $error("word present without credit");

endmodule

FILE: tb/tb_cartesian_to_polar.sv
// Self-checking testbench for cartesian_to_polar: directed, backpressure and random samples.
`timescale 1ns / 1ps

module tb_cartesian_to_polar;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 9;
  localparam int IDLE_LIMIT   = 1000;            // cycles with no word moving on either side
  localparam int TAIL_CYCLES  = cp_pkg::PIPE_LAT + 8;
  localparam int HOLD_CYCLES  = 160;             // long output stall, well past buffer + pipe
  localparam int PRESS_ITEMS  = 120;
  localparam int RAND_ITEMS   = 380;
  localparam int N_DIRECTED   = 21;

  // Axes, extremes, largest magnitude, and angles that round up to a full turn.
  localparam logic signed [15:0] DIR_RE [N_DIRECTED] = '{
    0, 32767, -32768, 0, 0, 1, -1, 0, 0, -32768, 32767,
    -32768, 32767, 1, -1, -1, 1, 32767, -32768, -32768, 3};
  localparam logic signed [15:0] DIR_IM [N_DIRECTED] = '{
    0, 0, 0, 32767, -32768, 0, 0, 1, -1, -32768, 32767,
    32767, -32768, 1, -1, 1, -1, -1, 1, -1, 4};

  typedef struct packed {
    logic [15:0] mag;
    logic [15:0] turn_phase;
  } polar_t;

  // Holds the polar words still owed by the block, oldest first.
  class polar_checker;
    polar_t      owed_polar[$];
    int unsigned atan_turn[cp_pkg::ITERS];
    int          errors;
    int          words_checked;

    function new();
      atan_turn = '{2097152, 1238021, 654136, 332050, 166669,
                    83416, 41718, 20860, 10430, 5215,
                    2608, 1304, 652, 326, 163,
                    81, 41, 20, 10, 5};
      errors = 0;
      words_checked = 0;
    endfunction

    // Exact rounded root for the magnitude, CORDIC vectoring for the angle.
    function polar_t to_polar(logic [15:0] re_raw, logic [15:0] im_raw);
      polar_t          p;
      longint          a, b, x, y, dx, dy;
      longint unsigned sq, rem, root, bitv;
      bit [31:0]       z, zr;
      a = longint'($signed(re_raw));
      b = longint'($signed(im_raw));
      sq = a * a + b * b;
      rem = sq;
      root = 0;
      bitv = 64'd1 << 30;
      while (bitv > rem)
        bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem = rem - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      if (sq > root * root + root)
        root = root + 1;
      p.mag = 16'(root);

      if (b == 0) begin
        p.turn_phase = (a < 0) ? 16'd32768 : 16'd0;
      end else if (a == 0) begin
        p.turn_phase = (b > 0) ? 16'd16384 : 16'd49152;
      end else begin
        // left half plane: flip the vector, start at half a turn
        if (a < 0) begin
          x = -a;
          y = -b;
          z = 32'h0080_0000;
        end else begin
          x = a;
          y = b;
          z = 32'd0;
        end
        x = x <<< cp_pkg::PRESHIFT;
        y = y <<< cp_pkg::PRESHIFT;
        for (int i = 0; i < cp_pkg::ITERS; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + atan_turn[i];
          end else begin
            x = x - dx;
            y = y + dy;
            z = z - atan_turn[i];
          end
        end
        zr = z + 32'd128;
        p.turn_phase = zr[23:8];   // wraps a full turn to 0
      end
      return p;
    endfunction

    function void note_sample(logic [15:0] re_raw, logic [15:0] im_raw);
      owed_polar.push_back(to_polar(re_raw, im_raw));
    endfunction

    function void check_word(cp_pkg::word_t w);
      polar_t exp_p;
      words_checked++;
      if (owed_polar.size() == 0) begin
        $error("unexpected output word %h with nothing outstanding", w);
        errors++;
        return;
      end
      exp_p = owed_polar.pop_front();
      if (w[15:0] !== exp_p.mag) begin
        $error("mag: expected %0d, actual %0d", exp_p.mag, w[15:0]);
        errors++;
      end
      if (w[31:16] !== exp_p.turn_phase) begin
        $error("turn_phase: expected %0d, actual %0d", exp_p.turn_phase, w[31:16]);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_polar.size();
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  cp_pkg::word_t s_axis_tdata;   // [15:0] re_part, [31:16] im_part
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  cp_pkg::word_t m_axis_tdata;   // [15:0] mag, [31:16] turn_phase

  polar_checker checker_h;
  bit           stall_request;   // sender asks the receiver for one long hold-off
  int           n_directed, n_pressed, n_random;

  cartesian_to_polar DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  // Offer one sample from the falling edge; return once it is taken.
  task automatic send_sample(logic [15:0] re_raw, logic [15:0] im_raw);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {im_raw, re_raw};
    do @(posedge clk); while (!s_axis_tready);
    checker_h.note_sample(re_raw, im_raw);
  endtask

  // Idle input: valid low, data scrambled so nothing leaks from stale words.
  task automatic input_gap(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= cp_pkg::word_t'($urandom);
    end
  endtask

  // Stop offering, wait for every owed word, then idle through a tail to catch any stray word.
  task automatic drain_outputs();
    input_gap(1);
    while (checker_h.outstanding() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Full range for five of twelve picks; the rest are small, zero, extreme and unit values.
  function automatic logic [15:0] pick_part();
    int k;
    k = $urandom_range(0, 11);
    case (k)
      0, 1, 2, 3, 4: pick_part = 16'($urandom_range(0, 65535));
      5, 6:          pick_part = 16'(int'($urandom_range(0, 32)) - 16);
      7:             pick_part = 16'd0;
      8:             pick_part = 16'h8000;
      9:             pick_part = 16'h7fff;
      10:            pick_part = $urandom_range(0, 1) ? 16'h0001 : 16'hffff;
      default:       pick_part = $urandom_range(0, 1) ? 16'h8001 : 16'h7ffe;
    endcase
  endfunction

  // Receiver: ready pattern chosen per span, with one long hold-off on request.
  initial begin : receiver
    int mode, span, hold_left, cyc;
    logic rdy;
    mode = 0;
    span = 0;
    hold_left = 0;
    cyc = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(20, 200);
        end
        span--;
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = ($urandom_range(0, 3) != 0);
          2:       rdy = ($urandom_range(0, 3) == 0);
          default: rdy = ((cyc % 5) != 2) && ((cyc % 7) != 0);
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  // Output monitor and watchdog: any cycle with no word moving counts toward the limit.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready)
        checker_h.check_word(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle = 0;
      else
        idle++;
    end
    $display("watchdog: no word moved for %0d cycles, %0d still owed",
             IDLE_LIMIT, checker_h.outstanding());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int burst, gap;
    checker_h     = new();
    stall_request = 1'b0;
    n_directed    = 0;
    n_pressed     = 0;
    n_random      = 0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners, back to back
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_sample(DIR_RE[i], DIR_IM[i]);
      n_directed++;
    end

    // sender pauses until every owed word is out
    drain_outputs();

    // long output stall while input keeps coming: buffer fills, tready drops
    stall_request = 1'b1;
    for (int i = 0; i < PRESS_ITEMS; i++) begin
      send_sample(pick_part(), pick_part());
      n_pressed++;
    end

    // random bursts with random gaps; some runs with no gaps at all
    while (n_random < RAND_ITEMS) begin
      burst = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      for (int i = 0; i < burst; i++) begin
        send_sample(pick_part(), pick_part());
        n_random++;
        if (gap != 0 && $urandom_range(0, 2) == 0)
          input_gap($urandom_range(1, gap));
      end
      input_gap(gap);
    end

    drain_outputs();

    $display("Sent %0d samples: %0d corner cases, %0d under a long output stall, %0d random.",
             n_directed + n_pressed + n_random, n_directed, n_pressed, n_random);
    $display("Checked %0d magnitude/phase words, %0d mismatches.",
             checker_h.words_checked, checker_h.errors);
    if (checker_h.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
